// ===== src/nlt_pkg.sv =====
`timescale 1ns / 1ps
package nlt_pkg;

	localparam int unsigned NOTE_LOW     = 21;
	localparam int unsigned NOTE_HIGH    = 108;
	localparam int unsigned NOTE_SPAN    = NOTE_HIGH - NOTE_LOW + 1;
	localparam int unsigned HUE_MOD      = 12;
	localparam int unsigned HUE_STEP     = 21;
	localparam int unsigned LEVEL_BASE   = 30;
	localparam int unsigned LEVEL_MAX    = 255;
	localparam int unsigned RESULT_LIMIT = 32;
	localparam int unsigned LED_W        = 12;

	localparam logic [15:0] DEFAULT_DUR_RST = 16'd200;
	localparam logic [15:0] MAX_DUR_RST     = 16'd8000;
	localparam logic [7:0]  DECAY_FLOOR_RST = 8'd10;

	localparam logic [1:0] REG_DEFAULT_DUR = 2'd0;
	localparam logic [1:0] REG_MAX_DUR     = 2'd1;
	localparam logic [1:0] REG_DECAY_FLOOR = 2'd2;

	localparam logic OP_NOTE_ON = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef enum logic [1:0] {
		KIND_STORED  = 2'd0,
		KIND_DROPPED = 2'd1,
		KIND_ACTIVE  = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [LED_W-1:0] led;
		logic [7:0]       hue;
		logic [7:0]       level;
		logic [31:0]      expiry;
	} entry_t;

endpackage

// ===== src/nlt_mem.sv =====
`timescale 1ns / 1ps
module nlt_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  nlt_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output nlt_pkg::entry_t rdata
);
	import nlt_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/nlt_note.sv =====
`timescale 1ns / 1ps
module nlt_note #(
	parameter int unsigned MATRIX_WIDTH  = 64,
	parameter int unsigned MATRIX_HEIGHT = 64
) (
	input  logic [7:0]      note,
	input  logic [15:0]     length_ms,
	input  logic [7:0]      velocity,
	input  logic [31:0]     now_ms,
	input  logic [15:0]     default_duration,
	input  logic [15:0]     max_duration,
	output nlt_pkg::entry_t entry
);
	import nlt_pkg::*;

	localparam int unsigned ROW = MATRIX_HEIGHT / 2;

	logic [LED_W-1:0] led_tab [NOTE_SPAN];
	logic [7:0]       hue_tab [256];
	logic [7:0]       note_c;
	logic [6:0]       offset;
	logic [9:0]       lvl_sum;
	logic [15:0]      dur;

	// led index per clamped note, folded at elaboration
	for (genvar g = 0; g < NOTE_SPAN; g++) begin : g_led
		localparam int unsigned COL_RAW = (g * MATRIX_WIDTH) / NOTE_SPAN;
		localparam int unsigned COL = (COL_RAW >= MATRIX_WIDTH) ? MATRIX_WIDTH - 1 : COL_RAW;
		localparam int unsigned IDX = ((ROW % 2) == 0) ? ROW * MATRIX_WIDTH + COL
			: ROW * MATRIX_WIDTH + MATRIX_WIDTH - 1 - COL;
		assign led_tab[g] = LED_W'(IDX);
	end

	for (genvar h = 0; h < 256; h++) begin : g_hue
		assign hue_tab[h] = 8'((h % HUE_MOD) * HUE_STEP);
	end

	always_comb begin
		if (note < 8'(NOTE_LOW)) begin
			note_c = 8'(NOTE_LOW);
		end else if (note > 8'(NOTE_HIGH)) begin
			note_c = 8'(NOTE_HIGH);
		end else begin
			note_c = note;
		end
		offset = 7'(note_c - 8'(NOTE_LOW));

		lvl_sum = {1'b0, velocity, 1'b0} + 10'(LEVEL_BASE);

		if (length_ms == 16'd0) begin
			dur = default_duration;
		end else if (length_ms < max_duration) begin
			dur = length_ms;
		end else begin
			dur = max_duration;
		end

		entry.led    = led_tab[offset];
		entry.hue    = hue_tab[note];
		entry.level  = (lvl_sum > 10'(LEVEL_MAX)) ? 8'(LEVEL_MAX) : lvl_sum[7:0];
		entry.expiry = now_ms + {16'd0, dur};
	end

endmodule

// ===== src/note_light_table_unit.sv =====
`timescale 1ns / 1ps
// channel  | dir | tdata (low bit up)                          | tuser     | tlast
// s_axis   | in  | note 8, length_ms 16, velocity 8, now 32    | operation | -
// m_axis   | out | led_index 12, hue 8, level 8, zero pad 4    | kind      | last
// cfg      | in  | cfg_wen, cfg_index 2 bits, cfg_wdata 16 bits, no read-back
//
// note on: the request is registered, then ST_NOTE loads the result into the output
// register once it is free; tick: the scan reads the stored entries one per scan cycle
// through the single read port of the entry memory and compacts the survivors, then
// each reported result takes a read and an output load (ST_EMIT_RD, ST_EMIT_OUT)
// arst_n clears the entry count and control state, presets config, not memory or data
// a stalled output holds each state that loads a result; input is taken only when idle
module note_light_table_unit #(
	parameter int unsigned MAX_NOTES     = 32,
	parameter int unsigned MATRIX_WIDTH  = 64,
	parameter int unsigned MATRIX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // note, length_ms, velocity, now_ms
	input  logic        s_axis_tuser,   // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // led_index, hue, level, zero pad
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast
);
	import nlt_pkg::*;

	localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int unsigned CW = $clog2(MAX_NOTES + 1);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_NOTE     = 6'b000010,
		ST_SCAN     = 6'b000100,
		ST_EMPTY    = 6'b001000,
		ST_EMIT_RD  = 6'b010000,
		ST_EMIT_OUT = 6'b100000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q, kept_q, idx_q, emit_last_q;
	logic          rv_s1;
	logic [15:0]   def_dur_q, max_dur_q;
	logic [7:0]    floor_q;
	logic [7:0]    note_q, vel_q;
	logic [15:0]   dur_q;
	logic [31:0]   now_q;

	logic             out_valid_q, out_last_q;
	kind_t            out_kind_q;
	logic [LED_W-1:0] out_led_q;
	logic [7:0]       out_hue_q, out_level_q;

	entry_t        note_entry, rdata, wdata;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;

	logic       out_free, has_room, in_take;
	logic [9:0] lv_x3;
	logic [7:0] lv_dec;
	logic [31:0] diff;
	logic       keep;

	logic             out_load, out_last_d;
	kind_t            out_kind_d;
	logic [LED_W-1:0] out_led_d;
	logic [7:0]       out_hue_d, out_level_d;

	nlt_note #(
		.MATRIX_WIDTH (MATRIX_WIDTH),
		.MATRIX_HEIGHT(MATRIX_HEIGHT)
	) u_note (
		.note            (note_q),
		.length_ms       (dur_q),
		.velocity        (vel_q),
		.now_ms          (now_q),
		.default_duration(def_dur_q),
		.max_duration    (max_dur_q),
		.entry           (note_entry)
	);

	nlt_mem #(
		.DEPTH(MAX_NOTES),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign has_room      = (cnt_q < CW'(MAX_NOTES));

	// decay and expiry of the entry read in the previous scan cycle
	always_comb begin
		lv_x3  = {2'b00, rdata.level} + {1'b0, rdata.level, 1'b0};
		lv_dec = (rdata.level > floor_q) ? lv_x3[9:2] : 8'd0;
		diff   = rdata.expiry - now_q;
		keep   = !(((diff == 32'd0) || diff[31]) && (lv_dec == 8'd0));
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = kept_q[AW-1:0];
		wdata     = '{led: rdata.led, hue: rdata.hue, level: lv_dec, expiry: rdata.expiry};
		case (state_q)
			ST_NOTE: begin
				mem_we    = out_free && has_room;
				mem_waddr = cnt_q[AW-1:0];
				wdata     = note_entry;
			end
			ST_SCAN: begin
				mem_re = (idx_q < cnt_q);
				mem_we = rv_s1 && keep;
			end
			ST_EMIT_RD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_load    = 1'b0;
		out_kind_d  = KIND_NONE;
		out_led_d   = '0;
		out_hue_d   = '0;
		out_level_d = '0;
		out_last_d  = 1'b1;
		case (state_q)
			ST_NOTE: begin
				out_load    = out_free;
				out_kind_d  = has_room ? KIND_STORED : KIND_DROPPED;
				out_led_d   = note_entry.led;
				out_hue_d   = note_entry.hue;
				out_level_d = note_entry.level;
			end
			ST_EMPTY: begin
				out_load = out_free;
			end
			ST_EMIT_OUT: begin
				out_load    = out_free;
				out_kind_d  = KIND_ACTIVE;
				out_led_d   = rdata.led;
				out_hue_d   = rdata.hue;
				out_level_d = rdata.level;
				out_last_d  = (idx_q == emit_last_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_dur_q <= DEFAULT_DUR_RST;
			max_dur_q <= MAX_DUR_RST;
			floor_q   <= DECAY_FLOOR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEFAULT_DUR: def_dur_q <= cfg_wdata;
				REG_MAX_DUR:     max_dur_q <= cfg_wdata;
				REG_DECAY_FLOOR: floor_q   <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			note_q <= s_axis_tdata[7:0];
			dur_q  <= s_axis_tdata[23:8];
			vel_q  <= s_axis_tdata[31:24];
			now_q  <= s_axis_tdata[63:32];
		end
		if (out_load) begin
			out_kind_q  <= out_kind_d;
			out_led_q   <= out_led_d;
			out_hue_q   <= out_hue_d;
			out_level_q <= out_level_d;
			out_last_q  <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			kept_q      <= '0;
			idx_q       <= '0;
			emit_last_q <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rv_s1 <= 1'b0;
					if (in_take) begin
						idx_q   <= '0;
						kept_q  <= '0;
						state_q <= (s_axis_tuser == OP_TICK) ? ST_SCAN : ST_NOTE;
					end
				end
				ST_NOTE: begin
					if (out_free) begin
						if (has_room) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rv_s1 <= mem_re;
					if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rv_s1 && keep) begin
						kept_q <= kept_q + CW'(1);
					end
					// compaction done once no read is issued or in flight
					if (!mem_re && !rv_s1) begin
						cnt_q <= kept_q;
						idx_q <= '0;
						if (8'(kept_q) > 8'(RESULT_LIMIT)) begin
							emit_last_q <= CW'(RESULT_LIMIT - 1);
						end else begin
							emit_last_q <= kept_q - CW'(1);
						end
						state_q <= (kept_q == '0) ? ST_EMPTY : ST_EMIT_RD;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (out_free) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= (idx_q == emit_last_q) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_level_q, out_hue_q, out_led_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/nlt_checker.sv =====
`timescale 1ns / 1ps
module nlt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import nlt_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// note and empty results are single
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_STORED || m_axis_tuser == KIND_DROPPED
			|| m_axis_tuser == KIND_NONE) |-> m_axis_tlast)
		else $error("single result without last");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_NONE |-> m_axis_tdata == 32'd0)
		else $error("empty result carries data");

endmodule

bind note_light_table_unit nlt_checker u_nlt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
